// ----- hw/rtl/nlt_pkg.sv -----
// Shared types and constants for the node liveness table.
// Used by node_liveness_table_core, nlt_event_checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package nlt_pkg;

  localparam int unsigned MAX_NODES_DEF = 32;
  localparam int unsigned MAX_RESULTS   = 32;
  localparam int unsigned DEF_BREAK     = 20;
  localparam int unsigned DEF_EXPIRE    = 200;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_BREAK  = 2'd0;
  localparam logic [1:0] CFG_EXPIRE = 2'd1;
  localparam logic [1:0] CFG_MCAST  = 2'd2;

  typedef enum logic [2:0] {
    OP_REG   = 3'd0,
    OP_DEREG = 3'd1,
    OP_ACT   = 3'd2,
    OP_TICK  = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    EV_NO_CHANGE = 4'd0,
    EV_ONLINE    = 4'd1,
    EV_OFFLINE   = 4'd2,
    EV_REMOVED   = 4'd3,
    EV_RESTARTED = 4'd4,
    EV_IGNORED   = 4'd5,
    EV_FULL      = 4'd6,
    EV_FOUND     = 4'd7,
    EV_NONE      = 4'd8
  } ev_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT2,
    S_TICK,
    S_TSEL,
    S_TOUT
  } state_e;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] stime;
    logic [15:0] misses;
    logic        online;
    logic        serving;
  } entry_t;

endpackage

// ----- hw/rtl/node_liveness_table_core.sv -----
// Heartbeat liveness table of peer nodes, keyed by node id.
// Depends on nlt_pkg for types, opcodes, event codes and defaults.
`timescale 1ns / 1ps

// Usage.
// An item (op, node id, start time, serving, cast flag) is taken on a rising
// edge where start_i is high and busy_o is low. Each result beat sits on the
// event ports for exactly one cycle with res_valid_o high; last_o marks the
// final beat of an item. The receiver cannot stall, so every beat is taken as
// it is shown. Configuration writes (index 0 break beats, 1 expire beats,
// 2 multicast mode) are accepted every cycle and are meant for idle periods.
// All entry fields live in one synchronous memory with a registered read
// port; a valid bit per entry sits in flip-flops, so reset empties the
// table at once and no clearing pass is needed.
// Register, deregister, activity and query read every entry once before the
// first result beat. A register that both restarts and revives a node gives
// a second beat in the cycle after the first.
// A tick sweeps the memory once with read-modify-write, then finds each
// reported event by a further pass over the keys. The sweep and search
// length are set by the single memory read port.
// Ignored registrations and unused opcodes answer without a scan.
// busy_o falls in the cycle in which the last beat is shown.
module node_liveness_table_core #(
  parameter int unsigned MAX_NODES = nlt_pkg::MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] node_id_i,
  input  logic [31:0] start_time_i,
  input  logic        serving_i,
  input  logic        unicast_flag_i,
  // Result channel.
  output logic        res_valid_o,
  output logic [3:0]  event_res_o,
  output logic [31:0] event_node_o,
  output logic [31:0] event_start_time_o,
  output logic        last_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned RC_W  = $clog2(nlt_pkg::MAX_RESULTS);

  // Configuration registers.
  logic [7:0]  brk_q;
  logic [15:0] exp_q;
  logic        mcast_q;

  // Sequencer state and scan counter.
  nlt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Latched command.
  logic [2:0]  op_q, op_d;
  logic [31:0] node_q, node_d;
  logic [31:0] time_q, time_d;
  logic        serv_q, serv_d;
  logic        uni_q, uni_d;

  // Per-entry flip-flops: valid bit, tick event flag and event kind.
  logic [MAX_NODES-1:0] valid_q, valid_d;
  logic [MAX_NODES-1:0] evf_q, evf_d;
  logic [MAX_NODES-1:0] evrm_q, evrm_d;

  // Lookup and search results gathered during a pass.
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  nlt_pkg::entry_t     hit_ent_q, hit_ent_d;
  logic                free_q, free_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic                best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [31:0]         best_key_q, best_key_d;
  logic [31:0]         best_time_q, best_time_d;
  logic [RC_W-1:0]     emit_cnt_q, emit_cnt_d;

  // Result register.
  logic        res_valid_q, res_valid_d;
  logic [3:0]  res_code_q, res_code_d;
  logic [31:0] res_node_q, res_node_d;
  logic [31:0] res_time_q, res_time_d;
  logic        res_last_q, res_last_d;

  // Entry memory.
  nlt_pkg::entry_t mem [MAX_NODES];
  nlt_pkg::entry_t rdata_q;
  nlt_pkg::entry_t mem_wdata;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  // Helper terms.
  logic             proc;
  logic             scan_end;
  logic [IDX_W-1:0] pidx;
  logic [7:0]       brk_eff;
  logic [15:0]      exp_eff;
  logic [15:0]      mis_inc;
  logic             t_off;
  logic             t_rm;
  logic             reg_ign;
  logic             reg_chg;
  logic             hit_off;
  logic             qry_take;
  logic             tsel_take;
  logic [MAX_NODES-1:0] evf_rest;
  logic             tout_last;

  // The data in rdata_q belongs to the entry addressed in the previous cycle, so
  // a pass processes entry cnt - 1 while it reads entry cnt.
  always_comb begin
    proc      = (cnt_q != '0);
    scan_end  = (cnt_q == CNT_W'(MAX_NODES));
    pidx      = IDX_W'(cnt_q - CNT_W'(1));
    mem_raddr = scan_end ? '0 : cnt_q[IDX_W-1:0];

    // A threshold of zero stands for the default.
    brk_eff = (brk_q == 8'd0) ? 8'(nlt_pkg::DEF_BREAK) : brk_q;
    exp_eff = (exp_q == 16'd0) ? 16'(nlt_pkg::DEF_EXPIRE) : exp_q;

    mis_inc = (rdata_q.misses == 16'hFFFF) ? rdata_q.misses : rdata_q.misses + 16'd1;
    t_off   = rdata_q.online && (mis_inc >= {8'h00, brk_eff});
    t_rm    = !rdata_q.online && (mis_inc >= exp_eff);

    reg_ign = (uni_q == mcast_q);
    reg_chg = (hit_ent_q.stime != time_q);
    hit_off = !hit_ent_q.online;

    qry_take  = proc && valid_q[pidx] && rdata_q.online && rdata_q.serving &&
                (!best_q || (rdata_q.key < best_key_q));
    tsel_take = proc && evf_q[pidx] && (!best_q || (rdata_q.key < best_key_q));

    evf_rest             = evf_q;
    evf_rest[best_idx_q] = 1'b0;
    tout_last = (evf_rest == '0) || (emit_cnt_q == RC_W'(nlt_pkg::MAX_RESULTS - 1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nlt_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (op_i)
            nlt_pkg::OP_REG: begin
              state_d = (unicast_flag_i == mcast_q) ? nlt_pkg::S_APPLY : nlt_pkg::S_SCAN;
            end
            nlt_pkg::OP_DEREG,
            nlt_pkg::OP_ACT,
            nlt_pkg::OP_QUERY: state_d = nlt_pkg::S_SCAN;
            nlt_pkg::OP_TICK:  state_d = nlt_pkg::S_TICK;
            default:           state_d = nlt_pkg::S_APPLY;
          endcase
        end
      end
      nlt_pkg::S_SCAN: begin
        if (scan_end) state_d = nlt_pkg::S_APPLY;
      end
      nlt_pkg::S_APPLY: begin
        if ((op_q == nlt_pkg::OP_REG) && !reg_ign && hit_q && reg_chg && hit_off) begin
          state_d = nlt_pkg::S_EMIT2;
        end else begin
          state_d = nlt_pkg::S_IDLE;
        end
      end
      nlt_pkg::S_EMIT2: state_d = nlt_pkg::S_IDLE;
      nlt_pkg::S_TICK: begin
        if (scan_end) state_d = nlt_pkg::S_TSEL;
      end
      nlt_pkg::S_TSEL: begin
        if ((cnt_q == '0) && (evf_q == '0)) begin
          state_d = nlt_pkg::S_IDLE;
        end else if (scan_end) begin
          state_d = nlt_pkg::S_TOUT;
        end
      end
      nlt_pkg::S_TOUT: begin
        state_d = tout_last ? nlt_pkg::S_IDLE : nlt_pkg::S_TSEL;
      end
      default: state_d = nlt_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory writes and result beats.
  always_comb begin
    cnt_d       = cnt_q;
    op_d        = op_q;
    node_d      = node_q;
    time_d      = time_q;
    serv_d      = serv_q;
    uni_d       = uni_q;
    valid_d     = valid_q;
    evf_d       = evf_q;
    evrm_d      = evrm_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_key_d  = best_key_q;
    best_time_d = best_time_q;
    emit_cnt_d  = emit_cnt_q;
    res_valid_d = 1'b0;
    res_code_d  = res_code_q;
    res_node_d  = res_node_q;
    res_time_d  = res_time_q;
    res_last_d  = res_last_q;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = hit_ent_q;

    unique case (state_q)
      nlt_pkg::S_IDLE: begin
        if (start_i) begin
          op_d       = op_i;
          node_d     = node_id_i;
          time_d     = start_time_i;
          serv_d     = serving_i;
          uni_d      = unicast_flag_i;
          cnt_d      = '0;
          evf_d      = '0;
          emit_cnt_d = '0;
        end
      end

      nlt_pkg::S_SCAN: begin
        cnt_d = scan_end ? '0 : cnt_q + CNT_W'(1);
        if (!proc) begin
          hit_d  = 1'b0;
          free_d = 1'b0;
          best_d = 1'b0;
        end else begin
          if (valid_q[pidx] && (rdata_q.key == node_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx;
            hit_ent_d = rdata_q;
          end
          if (!valid_q[pidx] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = pidx;
          end
          if (qry_take) begin
            best_d      = 1'b1;
            best_idx_d  = pidx;
            best_key_d  = rdata_q.key;
            best_time_d = rdata_q.stime;
          end
        end
      end

      nlt_pkg::S_APPLY: begin
        res_valid_d = 1'b1;
        res_code_d  = nlt_pkg::EV_NO_CHANGE;
        res_node_d  = node_q;
        res_time_d  = '0;
        res_last_d  = 1'b1;
        unique case (op_q)
          nlt_pkg::OP_REG: begin
            if (reg_ign) begin
              res_code_d = nlt_pkg::EV_IGNORED;
            end else if (!hit_q) begin
              if (!free_q) begin
                res_code_d = nlt_pkg::EV_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = free_idx_q;
                mem_wdata.key     = node_q;
                mem_wdata.stime   = time_q;
                mem_wdata.misses  = '0;
                mem_wdata.online  = 1'b1;
                mem_wdata.serving = serv_q;
                valid_d[free_idx_q] = 1'b1;
                res_code_d        = nlt_pkg::EV_ONLINE;
              end
            end else begin
              // Known node: a new start time means a restart; a node that
              // was offline also comes back online.
              mem_we            = 1'b1;
              mem_wdata.stime   = time_q;
              mem_wdata.misses  = '0;
              mem_wdata.online  = 1'b1;
              mem_wdata.serving = serv_q;
              if (reg_chg) begin
                res_code_d = nlt_pkg::EV_RESTARTED;
                res_last_d = !hit_off;
              end else if (hit_off) begin
                res_code_d = nlt_pkg::EV_ONLINE;
              end
            end
          end
          nlt_pkg::OP_DEREG: begin
            if (hit_q) begin
              mem_we            = 1'b1;
              mem_wdata.misses  = '0;
              mem_wdata.online  = 1'b0;
              mem_wdata.serving = 1'b0;
            end
          end
          nlt_pkg::OP_ACT: begin
            if (hit_q) begin
              mem_we           = 1'b1;
              mem_wdata.misses = '0;
              mem_wdata.online = 1'b1;
              if (hit_off) res_code_d = nlt_pkg::EV_ONLINE;
            end
          end
          nlt_pkg::OP_QUERY: begin
            res_code_d = best_q ? nlt_pkg::EV_FOUND : nlt_pkg::EV_NONE;
            res_node_d = best_q ? best_key_q : '0;
            res_time_d = best_q ? best_time_q : '0;
          end
          default: begin
            res_node_d = '0;
          end
        endcase
      end

      nlt_pkg::S_EMIT2: begin
        res_valid_d = 1'b1;
        res_code_d  = nlt_pkg::EV_ONLINE;
        res_node_d  = node_q;
        res_time_d  = '0;
        res_last_d  = 1'b1;
      end

      nlt_pkg::S_TICK: begin
        cnt_d = scan_end ? '0 : cnt_q + CNT_W'(1);
        if (proc && valid_q[pidx]) begin
          mem_we           = 1'b1;
          mem_waddr        = pidx;
          mem_wdata        = rdata_q;
          mem_wdata.misses = mis_inc;
          if (t_off) begin
            mem_wdata.online = 1'b0;
            evf_d[pidx]      = 1'b1;
            evrm_d[pidx]     = 1'b0;
          end else if (t_rm) begin
            // The key stays in memory so the removal can still be reported.
            valid_d[pidx] = 1'b0;
            evf_d[pidx]   = 1'b1;
            evrm_d[pidx]  = 1'b1;
          end
        end
      end

      nlt_pkg::S_TSEL: begin
        cnt_d = scan_end ? '0 : cnt_q + CNT_W'(1);
        if (!proc) begin
          best_d = 1'b0;
          if (evf_q == '0) begin
            res_valid_d = 1'b1;
            res_code_d  = nlt_pkg::EV_NO_CHANGE;
            res_node_d  = '0;
            res_time_d  = '0;
            res_last_d  = 1'b1;
          end
        end else if (tsel_take) begin
          best_d     = 1'b1;
          best_idx_d = pidx;
          best_key_d = rdata_q.key;
        end
      end

      nlt_pkg::S_TOUT: begin
        res_valid_d = 1'b1;
        res_code_d  = evrm_q[best_idx_q] ? nlt_pkg::EV_REMOVED : nlt_pkg::EV_OFFLINE;
        res_node_d  = best_key_q;
        res_time_d  = '0;
        res_last_d  = tout_last;
        evf_d[best_idx_q] = 1'b0;
        emit_cnt_d  = emit_cnt_q + RC_W'(1);
        cnt_d       = '0;
      end

      default: begin
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nlt_pkg::S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      evf_q       <= '0;
      res_valid_q <= 1'b0;
      brk_q       <= 8'(nlt_pkg::DEF_BREAK);
      exp_q       <= 16'(nlt_pkg::DEF_EXPIRE);
      mcast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      evf_q       <= evf_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          nlt_pkg::CFG_BREAK:  brk_q   <= cfg_data_i[7:0];
          nlt_pkg::CFG_EXPIRE: exp_q   <= cfg_data_i;
          nlt_pkg::CFG_MCAST:  mcast_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    node_q      <= node_d;
    time_q      <= time_d;
    serv_q      <= serv_d;
    uni_q       <= uni_d;
    evrm_q      <= evrm_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    best_key_q  <= best_key_d;
    best_time_q <= best_time_d;
    emit_cnt_q  <= emit_cnt_d;
    res_code_q  <= res_code_d;
    res_node_q  <= res_node_d;
    res_time_q  <= res_time_d;
    res_last_q  <= res_last_d;
  end

  assign busy_o             = (state_q != nlt_pkg::S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign res_valid_o        = res_valid_q;
  assign event_res_o        = res_code_q;
  assign event_node_o       = res_node_q;
  assign event_start_time_o = res_time_q;
  assign last_o             = res_last_q;

  // The first result of an item never shows up in the cycle after it is taken.
  a_no_beat_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !res_valid_o
  ) else $error("result beat right after an accepted item");

  // The final beat of an item coincides with the sequencer being free again.
  a_last_frees_block: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> !busy_o
  ) else $error("busy after the last beat of an item");

  // More beats of the same item are still to come after a non-final beat.
  a_more_beats_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o
  ) else $error("block idle while an item still owes beats");

endmodule

// ----- tb/sv/nlt_event_checker.sv -----
`timescale 1ns / 1ps
// Event checker for node_liveness_table_core: keeps its own copy of the peer
// table, works out the event beats of every accepted command and compares them.
// Depends on nlt_pkg for opcodes, event codes, register indexes and defaults.

module nlt_event_checker #(
  parameter int unsigned NODES = nlt_pkg::MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] node_id_i,
  input  logic [31:0] start_time_i,
  input  logic        serving_i,
  input  logic        unicast_flag_i,
  input  logic        res_valid_i,
  input  logic [3:0]  event_res_i,
  input  logic [31:0] event_node_i,
  input  logic [31:0] event_start_time_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        done_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  import nlt_pkg::*;

  localparam int unsigned PRINT_CAP = 60;

  typedef struct packed {
    logic [3:0]  res;
    logic [31:0] node;
    logic [31:0] stime;
    logic        last;
  } event_beat_t;

  // Mirrored table and settings.
  logic        slot_used    [NODES];
  logic [31:0] slot_key     [NODES];
  logic        slot_online  [NODES];
  logic        slot_serving [NODES];
  logic [31:0] slot_time    [NODES];
  logic [15:0] slot_misses  [NODES];
  logic [7:0]  break_beats;
  logic [15:0] expire_beats;
  logic        mcast_mode;

  event_beat_t predicted_beats [$];
  event_beat_t held_beat;
  bit          have_held;
  int unsigned item_beats;
  int unsigned mismatches;
  bit          closing_checked;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] event mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < NODES; i++) begin
      slot_used[i]    = 1'b0;
      slot_key[i]     = '0;
      slot_online[i]  = 1'b0;
      slot_serving[i] = 1'b0;
      slot_time[i]    = '0;
      slot_misses[i]  = '0;
    end
    break_beats  = 8'(DEF_BREAK);
    expire_beats = 16'(DEF_EXPIRE);
    mcast_mode   = 1'b0;
    have_held    = 1'b0;
    item_beats   = 0;
  endfunction

  // The newest beat is held back so that the final one can get its last mark.
  function automatic void add_beat(input ev_e ev, input logic [31:0] node,
                                   input logic [31:0] stime);
    if (item_beats >= MAX_RESULTS) return;
    if (have_held) predicted_beats.push_back(held_beat);
    held_beat  = '{res: ev, node: node, stime: stime, last: 1'b0};
    have_held  = 1'b1;
    item_beats++;
  endfunction

  function automatic void close_item(input logic [31:0] quiet_node);
    if (!have_held) add_beat(EV_NO_CHANGE, quiet_node, '0);
    held_beat.last = 1'b1;
    predicted_beats.push_back(held_beat);
    have_held  = 1'b0;
    item_beats = 0;
  endfunction

  function automatic int find_slot(input logic [31:0] key);
    for (int i = 0; i < NODES; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void register_peer(input logic [31:0] id, input logic [31:0] stamp,
                                        input logic serv, input logic uni);
    int   s;
    logic was_off;
    if (uni == mcast_mode) begin
      add_beat(EV_IGNORED, id, '0);
      return;
    end
    s = find_slot(id);
    if (s < 0) begin
      for (int i = 0; i < NODES; i++) begin
        if (s < 0 && !slot_used[i]) s = i;
      end
      if (s < 0) begin
        add_beat(EV_FULL, id, '0);
        return;
      end
      slot_used[s]    = 1'b1;
      slot_key[s]     = id;
      slot_online[s]  = 1'b1;
      slot_serving[s] = serv;
      slot_misses[s]  = '0;
      slot_time[s]    = stamp;
      add_beat(EV_ONLINE, id, '0);
      return;
    end
    was_off = !slot_online[s];
    if (slot_time[s] != stamp) begin
      slot_time[s] = stamp;
      add_beat(EV_RESTARTED, id, '0);
    end
    slot_online[s]  = 1'b1;
    slot_serving[s] = serv;
    slot_misses[s]  = '0;
    if (was_off) add_beat(EV_ONLINE, id, '0);
  endfunction

  // Ages every entry in ascending key order.
  function automatic void age_table();
    int          order [NODES];
    int          cnt;
    int          j;
    int          s;
    int unsigned brk;
    int unsigned expire_lim;
    logic [31:0] key;
    cnt        = 0;
    brk        = (break_beats != 0) ? break_beats : DEF_BREAK;
    expire_lim = (expire_beats != 0) ? expire_beats : DEF_EXPIRE;
    for (int i = 0; i < NODES; i++) begin
      if (slot_used[i]) begin
        j = cnt;
        while (j > 0 && slot_key[order[j-1]] > slot_key[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        cnt++;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      s = order[k];
      if (slot_misses[s] != 16'hFFFF) slot_misses[s]++;
      if (slot_online[s]) begin
        if (slot_misses[s] >= brk) begin
          slot_online[s] = 1'b0;
          add_beat(EV_OFFLINE, slot_key[s], '0);
        end
      end else if (slot_misses[s] >= expire_lim) begin
        key             = slot_key[s];
        slot_used[s]    = 1'b0;
        slot_key[s]     = '0;
        slot_serving[s] = 1'b0;
        slot_time[s]    = '0;
        slot_misses[s]  = '0;
        add_beat(EV_REMOVED, key, '0);
      end
    end
  endfunction

  function automatic void find_serving();
    int s;
    s = -1;
    for (int i = 0; i < NODES; i++) begin
      if (slot_used[i] && slot_online[i] && slot_serving[i] &&
          (s < 0 || slot_key[i] < slot_key[s])) s = i;
    end
    if (s >= 0) add_beat(EV_FOUND, slot_key[s], slot_time[s]);
    else        add_beat(EV_NONE, '0, '0);
  endfunction

  function automatic void apply_command(input logic [2:0] op, input logic [31:0] id,
                                        input logic [31:0] stamp, input logic serv,
                                        input logic uni);
    int s;
    case (op)
      OP_REG: register_peer(id, stamp, serv, uni);
      OP_DEREG: begin
        s = find_slot(id);
        if (s >= 0) begin
          slot_online[s]  = 1'b0;
          slot_serving[s] = 1'b0;
          slot_misses[s]  = '0;
        end
        add_beat(EV_NO_CHANGE, id, '0);
      end
      OP_ACT: begin
        s = find_slot(id);
        if (s >= 0) begin
          if (!slot_online[s]) add_beat(EV_ONLINE, id, '0);
          slot_online[s] = 1'b1;
          slot_misses[s] = '0;
        end
      end
      OP_TICK:  age_table();
      OP_QUERY: find_serving();
      default: ;
    endcase
    close_item((op <= OP_ACT) ? id : 32'd0);
  endfunction

  task automatic check_beat();
    event_beat_t want;
    if (predicted_beats.size() == 0) begin
      report_mismatch($sformatf("beat with nothing awaited: res %0d node %h",
                                event_res_i, event_node_i));
      return;
    end
    want = predicted_beats.pop_front();
    if (event_res_i !== want.res)
      report_mismatch($sformatf("event_res %0d, awaited %0d (node %h)",
                                event_res_i, want.res, want.node));
    if (event_node_i !== want.node)
      report_mismatch($sformatf("event_node %h, awaited %h", event_node_i, want.node));
    if (event_start_time_i !== want.stime)
      report_mismatch($sformatf("event_start_time %h, awaited %h",
                                event_start_time_i, want.stime));
    if (last_i !== want.last)
      report_mismatch($sformatf("last %b, awaited %b (node %h)", last_i, want.last,
                                want.node));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      predicted_beats.delete();
      mismatches      = 0;
      closing_checked = 1'b0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (res_valid_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BREAK:  break_beats  = cfg_data_i[7:0];
          CFG_EXPIRE: expire_beats = cfg_data_i;
          CFG_MCAST:  mcast_mode   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        apply_command(op_i, node_id_i, start_time_i, serving_i, unicast_flag_i);
      if (done_i && !closing_checked) begin
        closing_checked = 1'b1;
        if (predicted_beats.size() != 0)
          report_mismatch($sformatf("%0d awaited beats never arrived",
                                    predicted_beats.size()));
      end
      fail_count_o  <= mismatches;
      outstanding_o <= predicted_beats.size();
    end
  end

endmodule

// ----- tb/sv/tb_node_liveness_table_core.sv -----
`timescale 1ns / 1ps
// Top of the node_liveness_table_core regression: clock, reset, command and
// configuration stimulus, and the verdict. Needs nlt_pkg and nlt_event_checker.

module tb_node_liveness_table_core;

  import nlt_pkg::*;

  localparam int unsigned NODES         = MAX_NODES_DEF;
  localparam int unsigned POOL_SIZE     = 40;
  // Upper bound on the length of the whole run, enforced by the watchdog.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Idle wait after the final drain, before the verdict is taken.
  localparam int unsigned SETTLE_CYCLES = NODES + 8;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cmd_start    = 1'b0;
  logic        busy;
  logic [2:0]  cmd_op       = OP_QUERY;
  logic [31:0] cmd_node     = '0;
  logic [31:0] cmd_time     = '0;
  logic        cmd_serving  = 1'b0;
  logic        cmd_unicast  = 1'b0;
  logic        res_valid;
  logic [3:0]  event_res;
  logic [31:0] event_node;
  logic [31:0] event_time;
  logic        event_last;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = CFG_BREAK;
  logic [15:0] cfg_data     = '0;
  logic        table_done   = 1'b0;
  int unsigned fail_count;
  int unsigned outstanding;

  // Stimulus-side view of the link mode, so that registrations can be made
  // mostly well-formed (cast flag opposite to the mode) with a few ignored.
  logic        link_mcast   = 1'b0;
  bit          steady_sender = 1'b0;
  logic [31:0] peer_ids   [POOL_SIZE];
  logic [31:0] peer_times [POOL_SIZE];

  always #5 clk = ~clk;

  node_liveness_table_core #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start_i            (cmd_start),
    .busy_o             (busy),
    .op_i               (cmd_op),
    .node_id_i          (cmd_node),
    .start_time_i       (cmd_time),
    .serving_i          (cmd_serving),
    .unicast_flag_i     (cmd_unicast),
    .res_valid_o        (res_valid),
    .event_res_o        (event_res),
    .event_node_o       (event_node),
    .event_start_time_o (event_time),
    .last_o             (event_last),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  nlt_event_checker #(
    .NODES(NODES)
  ) event_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start_i            (cmd_start),
    .busy_i             (busy),
    .op_i               (cmd_op),
    .node_id_i          (cmd_node),
    .start_time_i       (cmd_time),
    .serving_i          (cmd_serving),
    .unicast_flag_i     (cmd_unicast),
    .res_valid_i        (res_valid),
    .event_res_i        (event_res),
    .event_node_i       (event_node),
    .event_start_time_i (event_time),
    .last_i             (event_last),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .done_i             (table_done),
    .fail_count_o       (fail_count),
    .outstanding_o      (outstanding)
  );

  // Presents one command beat and returns at the edge that accepts it. The
  // start line is left high so that a following beat with no gap goes out
  // straight away; it is only lowered when a gap is drawn or the table drains.
  task automatic send_item(input logic [2:0] op, input logic [31:0] id,
                           input logic [31:0] stamp, input logic serv,
                           input logic uni);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_start   <= 1'b1;
    cmd_op      <= op;
    cmd_node    <= id;
    cmd_time    <= stamp;
    cmd_serving <= serv;
    cmd_unicast <= uni;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Switch now and then between gapped traffic and back-to-back stretches.
    if ($urandom_range(0, 9) == 0) steady_sender = ~steady_sender;
  endtask

  // Holds the sender off until every awaited beat has come and the block has
  // gone idle. The checker's count is registered, so it is read only after the next edge.
  task automatic drain_table();
    cmd_start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic program_table(input logic [7:0] brk, input logic [15:0] expire,
                               input logic mcast);
    logic [1:0]  regs   [3];
    logic [15:0] values [3];
    regs[0]   = CFG_BREAK;
    regs[1]   = CFG_EXPIRE;
    regs[2]   = CFG_MCAST;
    values[0] = {8'd0, brk};
    values[1] = expire;
    values[2] = {15'd0, mcast};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= values[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    link_mcast  = mcast;
  endtask

  function automatic logic [31:0] fresh_id();
    logic [31:0] id;
    id = $urandom;
    // All ones is outside the node id range.
    if (id == 32'hFFFF_FFFF) id = 32'h7FFF_FFFF;
    return id;
  endfunction

  // Mostly ids from the pool so that lookups hit; now and then a stranger.
  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 4) == 0) return fresh_id();
    return peer_ids[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // One random command. Registrations keep a stable start time per peer
  // most of the time, so that a changed time (a restart) stays the exception.
  task automatic random_item();
    int unsigned pick;
    int unsigned p;
    logic        uni;
    pick = $urandom_range(0, 99);
    p    = $urandom_range(0, POOL_SIZE - 1);
    uni  = ($urandom_range(0, 99) < 15) ? link_mcast : ~link_mcast;
    if (pick < 36) begin
      if ($urandom_range(0, 4) == 0) peer_times[p] = $urandom;
      send_item(OP_REG, peer_ids[p], peer_times[p], 1'($urandom_range(0, 1)), uni);
    end else if (pick < 48) begin
      send_item(OP_DEREG, pick_id(), $urandom, 1'($urandom_range(0, 1)), uni);
    end else if (pick < 62) begin
      send_item(OP_ACT, pick_id(), $urandom, 1'($urandom_range(0, 1)), uni);
    end else if (pick < 80) begin
      send_item(OP_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)), uni);
    end else if (pick < 95) begin
      send_item(OP_QUERY, $urandom, $urandom, 1'($urandom_range(0, 1)), uni);
    end else begin
      // Opcodes past the query are unused and answer with a single beat.
      send_item(3'($urandom_range(5, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                uni);
    end
    // Every so often the sender waits for the table to answer everything.
    if ($urandom_range(0, 24) == 0) drain_table();
  endtask

  task automatic random_phase(input int unsigned count);
    for (int n = 0; n < count; n++) random_item();
  endtask

  // Watchdog: a hung handshake or a lost beat ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("node_liveness_table_core regression: fail");
    $finish;
  end

  initial begin
    for (int p = 0; p < POOL_SIZE; p++) begin
      peer_ids[p]   = fresh_id();
      peer_times[p] = $urandom;
    end
    // The extremes of the id range are always part of the pool.
    peer_ids[0] = 32'h0000_0000;
    peer_ids[1] = 32'hFFFF_FFFE;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part, with the reset settings: a unicast registration is taken,
    // a multicast one is ignored.
    send_item(OP_QUERY, '0, '0, 1'b0, 1'b0);                     // empty table
    send_item(OP_TICK,  '0, '0, 1'b0, 1'b0);                     // tick, no event
    send_item(OP_REG, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1); // new node
    send_item(OP_REG, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b1); // new node
    send_item(OP_REG, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1); // refresh only
    send_item(OP_REG, 32'h0000_0000, 32'h0000_1234, 1'b1, 1'b1); // restart of an online node
    send_item(OP_DEREG, 32'h0000_0000, '0, 1'b0, 1'b0);
    send_item(OP_REG, 32'h0000_0000, 32'h0000_1234, 1'b1, 1'b1); // back online
    send_item(OP_DEREG, 32'h0000_0000, '0, 1'b0, 1'b0);
    // Offline node with a new start time: restart and online, two beats.
    send_item(OP_REG, 32'h0000_0000, 32'hA5A5_5A5A, 1'b1, 1'b1);
    send_item(OP_REG, 32'h0000_0077, 32'h0000_0001, 1'b1, 1'b0); // ignored
    send_item(OP_DEREG, 32'h1234_5678, '0, 1'b1, 1'b1);          // unknown node
    send_item(OP_ACT,   32'h1234_5678, '0, 1'b1, 1'b1);          // unknown node
    send_item(OP_DEREG, 32'hFFFF_FFFE, '0, 1'b0, 1'b0);
    send_item(OP_ACT,   32'hFFFF_FFFE, '0, 1'b0, 1'b0);          // revived
    send_item(OP_ACT,   32'hFFFF_FFFE, '0, 1'b0, 1'b0);          // already online
    send_item(OP_QUERY, '0, '0, 1'b0, 1'b0);                     // finds node 0
    send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);   // unused opcodes
    send_item(3'd6, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_item(3'd7, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);
    send_item(OP_TICK, '0, '0, 1'b0, 1'b0);

    // Short thresholds on a multicast link: nodes age out quickly.
    drain_table();
    program_table(8'd3, 16'd5, 1'b1);
    random_phase(30);

    // Thresholds of one: fill the table past its size, then age it with ticks
    // that report an event for every entry.
    drain_table();
    program_table(8'd1, 16'd1, 1'b0);
    for (int k = 0; k < NODES + 2; k++) begin
      send_item(OP_REG, fresh_id(), $urandom, 1'($urandom_range(0, 1)), ~link_mcast);
    end
    send_item(OP_TICK, '0, '0, 1'b0, 1'b0);
    send_item(OP_TICK, '0, '0, 1'b0, 1'b0);
    random_phase(20);

    // Largest thresholds.
    drain_table();
    program_table(8'd255, 16'hFFFF, 1'b1);
    random_phase(20);

    // Zero thresholds fall back to the defaults.
    drain_table();
    program_table(8'd0, 16'd0, 1'b0);
    random_phase(20);

    drain_table();
    repeat (SETTLE_CYCLES) @(posedge clk);
    table_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("node_liveness_table_core regression: pass");
    end else begin
      $display("node_liveness_table_core regression: fail");
    end
    $finish;
  end

endmodule
